@@ rtl/bbwt_pkg.sv @@
// shared types and constants of the world box transform block
package bbwt_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_Z   = 3'd5;

    localparam logic [30:0] HALF_RESET = 31'd32768;

    typedef struct packed {
        logic signed [31:0] m_r0_c0;
        logic signed [31:0] m_r0_c1;
        logic signed [31:0] m_r0_c2;
        logic signed [31:0] m_r1_c0;
        logic signed [31:0] m_r1_c1;
        logic signed [31:0] m_r1_c2;
        logic signed [31:0] m_r2_c0;
        logic signed [31:0] m_r2_c1;
        logic signed [31:0] m_r2_c2;
        logic signed [31:0] m_r3_c0;
        logic signed [31:0] m_r3_c1;
        logic signed [31:0] m_r3_c2;
    } t_matrix;

    typedef struct packed {
        logic               changed;
        logic signed [31:0] world_center_x;
        logic signed [31:0] world_center_y;
        logic signed [31:0] world_center_z;
        logic        [30:0] world_extent_x;
        logic        [30:0] world_extent_y;
        logic        [30:0] world_extent_z;
    } t_box;

    typedef struct packed {
        logic    hit;
        t_matrix matrix;
    } t_job;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
    } t_cfg_ctl;

endpackage

@@ rtl/bbwt_in_if.sv @@
// matrix input channel
interface bbwt_in_if;
    logic              valid;
    logic              ready;
    bbwt_pkg::t_matrix data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/bbwt_out_if.sv @@
// world box output channel
interface bbwt_out_if;
    logic           valid;
    logic           ready;
    bbwt_pkg::t_box data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/bbwt_front.sv @@
// front end: matrix cache compare and job classification
module bbwt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bbwt_pkg::t_cfg_ctl  i_cfg,
    input  logic                i_valid,
    input  bbwt_pkg::t_matrix   i_matrix,
    input  logic                i_q_full,
    output logic                o_ready,
    output logic                o_push,
    output bbwt_pkg::t_job      o_job
);
    logic              r_cache_valid;
    bbwt_pkg::t_matrix r_cache;

    assign o_ready    = !i_q_full;
    assign o_push     = i_valid && !i_q_full;
    assign o_job.hit  = r_cache_valid && (i_matrix == r_cache);
    assign o_job.matrix = i_matrix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_valid <= 1'b0;
        end else begin
            if (o_push) begin
                r_cache_valid <= 1'b1;
            end
            // any write in range drops the cache
            if (i_cfg.we && i_cfg.idx <= bbwt_pkg::CFG_HALF_Z) begin
                r_cache_valid <= 1'b0;
            end
        end
        if (o_push) begin
            r_cache <= i_matrix;
        end
    end
endmodule

@@ rtl/bbwt_queue.sv @@
// short job queue between front and back
module bbwt_queue #(
    parameter int unsigned DEPTH = bbwt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bbwt_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output bbwt_pkg::t_job o_job
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    bbwt_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end
endmodule

@@ rtl/bbwt_back.sv @@
// back end: corner transform pipeline, min/max, center/extent and held box
module bbwt_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bbwt_pkg::t_cfg_ctl              i_cfg,
    input  logic [bbwt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_q_empty,
    input  bbwt_pkg::t_job                  i_job,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output bbwt_pkg::t_box                  o_box
);
    logic signed [31:0] r_center [3];
    logic        [30:0] r_half [3];

    logic               en;
    // stage 1: corners
    logic               r1_v, r1_hit;
    bbwt_pkg::t_matrix  r1_m;
    logic signed [31:0] r1_clo [3];
    logic signed [31:0] r1_chi [3];
    logic signed [31:0] n_clo [3];
    logic signed [31:0] n_chi [3];
    // stage 2: products
    logic               r2_v, r2_hit;
    logic signed [63:0] r2_plo [3][3];
    logic signed [63:0] r2_phi [3][3];
    logic signed [31:0] r2_t [3];
    logic signed [31:0] lin [3][3];
    // stage 3: per axis bounds
    logic               r3_v, r3_hit;
    logic signed [49:0] r3_lo [3];
    logic signed [49:0] r3_hi [3];
    logic signed [49:0] n_lo [3];
    logic signed [49:0] n_hi [3];
    // output
    logic               r_ov;
    bbwt_pkg::t_box     r_box;
    logic signed [31:0] r_held_c [3];
    logic        [30:0] r_held_e [3];
    logic signed [31:0] n_c [3];
    logic        [30:0] n_e [3];

    assign en      = !r_ov || i_ready;
    assign o_pop   = en && !i_q_empty;
    assign o_valid = r_ov;
    assign o_box   = r_box;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_center[i] <= '0;
                r_half[i]   <= bbwt_pkg::HALF_RESET;
            end
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                bbwt_pkg::CFG_CENTER_X: r_center[0] <= i_cfg_data;
                bbwt_pkg::CFG_CENTER_Y: r_center[1] <= i_cfg_data;
                bbwt_pkg::CFG_CENTER_Z: r_center[2] <= i_cfg_data;
                bbwt_pkg::CFG_HALF_X:   r_half[0]   <= i_cfg_data[30:0];
                bbwt_pkg::CFG_HALF_Y:   r_half[1]   <= i_cfg_data[30:0];
                bbwt_pkg::CFG_HALF_Z:   r_half[2]   <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // corners saturated to 32 bits
    always_comb begin
        logic signed [32:0] lo, hi;
        for (int i = 0; i < 3; i++) begin
            lo = 33'(r_center[i]) - $signed({2'b00, r_half[i]});
            hi = 33'(r_center[i]) + $signed({2'b00, r_half[i]});
            n_clo[i] = (lo < -33'sd2147483648) ? 32'sh8000_0000 : lo[31:0];
            n_chi[i] = (hi > 33'sd2147483647) ? 32'sh7fff_ffff : hi[31:0];
        end
    end

    always_comb begin
        lin[0][0] = r1_m.m_r0_c0; lin[0][1] = r1_m.m_r0_c1; lin[0][2] = r1_m.m_r0_c2;
        lin[1][0] = r1_m.m_r1_c0; lin[1][1] = r1_m.m_r1_c1; lin[1][2] = r1_m.m_r1_c2;
        lin[2][0] = r1_m.m_r2_c0; lin[2][1] = r1_m.m_r2_c1; lin[2][2] = r1_m.m_r2_c2;
    end

    // min and max separate per axis, so the box bounds are sums of per term extremes
    always_comb begin
        logic signed [47:0] a, b;
        for (int j = 0; j < 3; j++) begin
            n_lo[j] = 50'(r2_t[j]);
            n_hi[j] = 50'(r2_t[j]);
            for (int i = 0; i < 3; i++) begin
                a = r2_plo[i][j][63:16];
                b = r2_phi[i][j][63:16];
                n_lo[j] = n_lo[j] + 50'((a < b) ? a : b);
                n_hi[j] = n_hi[j] + 50'((a < b) ? b : a);
            end
        end
    end

    always_comb begin
        logic signed [50:0] s, d;
        for (int j = 0; j < 3; j++) begin
            s = 51'(r3_lo[j]) + 51'(r3_hi[j]);
            d = 51'(r3_hi[j]) - 51'(r3_lo[j]);
            if ($signed(s[50:1]) > 50'sd2147483647) begin
                n_c[j] = 32'sh7fff_ffff;
            end else if ($signed(s[50:1]) < -50'sd2147483648) begin
                n_c[j] = 32'sh8000_0000;
            end else begin
                n_c[j] = s[32:1];
            end
            n_e[j] = (d[50:1] > 50'sd2147483647) ? 31'h7fff_ffff : d[31:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r_ov <= 1'b0;
            for (int j = 0; j < 3; j++) begin
                r_held_c[j] <= '0;
                r_held_e[j] <= '0;
            end
        end else if (en) begin
            r1_v <= o_pop;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r_ov <= r3_v;
            if (r3_v && !r3_hit) begin
                for (int j = 0; j < 3; j++) begin
                    r_held_c[j] <= n_c[j];
                    r_held_e[j] <= n_e[j];
                end
            end
        end
        if (en) begin
            r1_hit <= i_job.hit;
            r1_m   <= i_job.matrix;
            for (int i = 0; i < 3; i++) begin
                r1_clo[i] <= n_clo[i];
                r1_chi[i] <= n_chi[i];
            end
            r2_hit <= r1_hit;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r2_plo[i][j] <= 64'(r1_clo[i]) * 64'(lin[i][j]);
                    r2_phi[i][j] <= 64'(r1_chi[i]) * 64'(lin[i][j]);
                end
            end
            r2_t[0] <= r1_m.m_r3_c0;
            r2_t[1] <= r1_m.m_r3_c1;
            r2_t[2] <= r1_m.m_r3_c2;
            r3_hit <= r2_hit;
            for (int j = 0; j < 3; j++) begin
                r3_lo[j] <= n_lo[j];
                r3_hi[j] <= n_hi[j];
            end
            r_box.changed <= !r3_hit;
            r_box.world_center_x <= r3_hit ? r_held_c[0] : n_c[0];
            r_box.world_center_y <= r3_hit ? r_held_c[1] : n_c[1];
            r_box.world_center_z <= r3_hit ? r_held_c[2] : n_c[2];
            r_box.world_extent_x <= r3_hit ? r_held_e[0] : n_e[0];
            r_box.world_extent_y <= r3_hit ? r_held_e[1] : n_e[1];
            r_box.world_extent_z <= r3_hit ? r_held_e[2] : n_e[2];
        end
    end
endmodule

@@ rtl/box_bound_world_transform_core.sv @@
// top level of the world box transform block
//  channel | dir | handshake       | payload
//  i_in    | in  | valid / ready   | 12 matrix elements, Q16.16
//  o_out   | out | valid / ready   | changed, world center xyz, world extent xyz
//  i_cfg   | in  | i_cfg_we        | i_cfg_idx, i_cfg_data
// one transaction per cycle sustained while o_out is ready; from input accept to output valid an item
// passes the queue, corners, products, bounds and output register
// the queue takes items while the back end stalls on o_out; ready drops only when it is full
// synchronous active-low reset clears the cache, the held box (to zero) and all valids
module box_bound_world_transform_core #(
    parameter int unsigned QUEUE_DEPTH = bbwt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    bbwt_in_if.sink                          i_in,
    bbwt_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [bbwt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bbwt_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    bbwt_pkg::t_cfg_ctl cfg;
    bbwt_pkg::t_job     push_job, pop_job;
    logic               push, pop, q_full, q_empty;

    assign cfg.we  = i_cfg_we;
    assign cfg.idx = i_cfg_idx;

    bbwt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (i_in.valid),
        .i_matrix (i_in.data),
        .i_q_full (q_full),
        .o_ready  (i_in.ready),
        .o_push   (push),
        .o_job    (push_job)
    );

    bbwt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (pop_job)
    );

    bbwt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_cfg_data (i_cfg_data),
        .i_q_empty  (q_empty),
        .i_job      (pop_job),
        .o_pop      (pop),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_box      (o_out.data)
    );
endmodule

@@ tb/sv/testbench.sv @@
// self-checking testbench of the world box transform block
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_PHASES   = 8;
    localparam int PHASE_ITEMS = 185;
    localparam int DRAIN_CYCLES = 12;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [bbwt_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [bbwt_pkg::CFG_DATA_W-1:0] i_cfg_data;

    bbwt_in_if  in_ch ();
    bbwt_out_if out_ch ();

    box_bound_world_transform_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow of the block's configuration and box cache
    logic signed [31:0] box_center [3];
    logic        [30:0] box_half   [3];
    logic               box_cache_valid;
    bbwt_pkg::t_matrix  cached_mx;
    bbwt_pkg::t_box     held_box;

    bbwt_pkg::t_matrix pending_mx [$];
    bbwt_pkg::t_box    expected_box [$];
    int      n_errors;
    int      burst_left;
    int      gap_left;
    int      ready_mode;
    int      cycle_cnt;
    int      hold_left;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint sat_s32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // world box of the local box under mx, updating the cache
    function automatic bbwt_pkg::t_box predict_world_box(bbwt_pkg::t_matrix mx);
        logic signed [31:0] e [12];
        longint lo [3];
        longint hi [3];
        longint c [3];
        longint p;
        longint ctr;
        longint ext;
        bbwt_pkg::t_box b;
        e = '{mx.m_r0_c0, mx.m_r0_c1, mx.m_r0_c2, mx.m_r1_c0, mx.m_r1_c1, mx.m_r1_c2,
              mx.m_r2_c0, mx.m_r2_c1, mx.m_r2_c2, mx.m_r3_c0, mx.m_r3_c1, mx.m_r3_c2};
        if (box_cache_valid && mx === cached_mx) begin
            b = held_box;
            b.changed = 1'b0;
            return b;
        end
        for (int k = 0; k < 8; k++) begin
            for (int i = 0; i < 3; i++) begin
                if (k & (1 << i))
                    c[i] = sat_s32(longint'(box_center[i]) + longint'({1'b0, box_half[i]}));
                else
                    c[i] = sat_s32(longint'(box_center[i]) - longint'({1'b0, box_half[i]}));
            end
            for (int j = 0; j < 3; j++) begin
                p = longint'(e[9+j]);
                for (int i = 0; i < 3; i++)
                    p += (c[i] * longint'(e[i*3+j])) >>> 16;
                if (k == 0 || p < lo[j]) lo[j] = p;
                if (k == 0 || p > hi[j]) hi[j] = p;
            end
        end
        for (int j = 0; j < 3; j++) begin
            ctr = sat_s32((lo[j] + hi[j]) >>> 1);
            ext = (hi[j] - lo[j]) >>> 1;
            if (ext > 64'sd2147483647) ext = 64'sd2147483647;
            case (j)
                0: begin b.world_center_x = ctr[31:0]; b.world_extent_x = ext[30:0]; end
                1: begin b.world_center_y = ctr[31:0]; b.world_extent_y = ext[30:0]; end
                default: begin b.world_center_z = ctr[31:0]; b.world_extent_z = ext[30:0]; end
            endcase
        end
        b.changed = 1'b1;
        held_box = b;
        cached_mx = mx;
        box_cache_valid = 1'b1;
        return b;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            4, 5, 6: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
            default: return $urandom();
        endcase
    endfunction

    function automatic bbwt_pkg::t_matrix random_matrix();
        bbwt_pkg::t_matrix mx;
        logic [31:0] v [12];
        for (int i = 0; i < 12; i++) v[i] = pick_value();
        mx = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10], v[11]};
        return mx;
    endfunction

    function automatic bbwt_pkg::t_matrix fill_matrix(logic [31:0] lin, logic [31:0] diag,
                                                      logic [31:0] tr);
        bbwt_pkg::t_matrix mx;
        mx = {diag, lin, lin, lin, diag, lin, lin, lin, diag, tr, tr, tr};
        return mx;
    endfunction

    task automatic write_reg(logic [bbwt_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx <= bbwt_pkg::CFG_CENTER_Z) begin
            box_center[idx] = val;
            box_cache_valid = 1'b0;
        end else if (idx <= bbwt_pkg::CFG_HALF_Z) begin
            box_half[idx - bbwt_pkg::CFG_HALF_X] = val[30:0];
            box_cache_valid = 1'b0;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        wait (pending_mx.size() == 0 && expected_box.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            n_errors++;
        end
    endtask

    // matrix driver: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            burst_left  <= 0;
            gap_left    <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_box.push_back(predict_world_box(pending_mx[0]));
                void'(pending_mx.pop_front());
            end
            if (in_ch.valid && !in_ch.ready) begin
                // transaction still waiting: keep valid and data
            end else if (gap_left > 0) begin
                gap_left    <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_mx.size() > 0) begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= pending_mx[0];
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, so the input queue fills and ready drops
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cycle_cnt <= 0;
            hold_left <= 0;
        end else begin
            cycle_cnt <= cycle_cnt + 1;
            if (cycle_cnt % 3000 == 1500) hold_left <= 150;
            else if (hold_left > 0) hold_left <= hold_left - 1;
        end
    end

    // receiver stall pattern, with the mode picked at random from three
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            ready_mode   <= 0;
        end else begin
            if (cycle_cnt % 64 == 0) ready_mode <= $urandom_range(0, 2);
            case (ready_mode)
                0: out_ch.ready <= (hold_left == 0);
                1: out_ch.ready <= (hold_left == 0) && ($urandom_range(0, 1) == 0);
                default: out_ch.ready <= (hold_left == 0) && ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_box.size() == 0) begin
                $error("world box transaction with nothing expected");
                n_errors++;
            end else begin
                check_field("changed", 32'(expected_box[0].changed), 32'(out_ch.data.changed));
                check_field("world_center_x", expected_box[0].world_center_x,
                            out_ch.data.world_center_x);
                check_field("world_center_y", expected_box[0].world_center_y,
                            out_ch.data.world_center_y);
                check_field("world_center_z", expected_box[0].world_center_z,
                            out_ch.data.world_center_z);
                check_field("world_extent_x", 32'(expected_box[0].world_extent_x),
                            32'(out_ch.data.world_extent_x));
                check_field("world_extent_y", 32'(expected_box[0].world_extent_y),
                            32'(out_ch.data.world_extent_y));
                check_field("world_extent_z", 32'(expected_box[0].world_extent_z),
                            32'(out_ch.data.world_extent_z));
                void'(expected_box.pop_front());
            end
        end
    end

    initial begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        bbwt_pkg::t_matrix mx;
        bbwt_pkg::t_matrix prev;
        n_errors        = 0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.data      = '0;
        box_cache_valid = 1'b0;
        cached_mx       = '0;
        held_box        = '0;
        for (int i = 0; i < 3; i++) begin
            box_center[i] = '0;
            box_half[i]   = bbwt_pkg::HALF_RESET;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: identity, cache hit, zero, extremes, translation extremes
        pending_mx.push_back(fill_matrix(32'h0, 32'h1_0000, 32'h0));
        pending_mx.push_back(fill_matrix(32'h0, 32'h1_0000, 32'h0));
        pending_mx.push_back('0);
        pending_mx.push_back(fill_matrix(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        pending_mx.push_back(fill_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        pending_mx.push_back(fill_matrix(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
        pending_mx.push_back(fill_matrix(32'hffff_ffff, 32'h0001_0000, 32'h7fff_ffff));
        pending_mx.push_back(fill_matrix(32'hffff_ffff, 32'h0001_0000, 32'h7fff_ffff));
        wait_idle();
        // extreme box: saturating corners, then an out-of-range index keeps the cache
        write_reg(bbwt_pkg::CFG_CENTER_X, 32'h7fff_ffff);
        write_reg(bbwt_pkg::CFG_CENTER_Y, 32'h8000_0000);
        write_reg(bbwt_pkg::CFG_CENTER_Z, 32'h0);
        write_reg(bbwt_pkg::CFG_HALF_X, 32'hffff_ffff);
        write_reg(bbwt_pkg::CFG_HALF_Y, 32'h7fff_ffff);
        write_reg(bbwt_pkg::CFG_HALF_Z, 32'h0);
        pending_mx.push_back(fill_matrix(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
        pending_mx.push_back(fill_matrix(32'h0, 32'h1_0000, 32'h8000_0000));
        wait_idle();
        write_reg(3'd6, $urandom());
        write_reg(3'd7, $urandom());
        pending_mx.push_back(fill_matrix(32'h0, 32'h1_0000, 32'h8000_0000));
        pending_mx.push_back(fill_matrix(32'h0, 32'h1_0000, 32'h8000_0000));
        wait_idle();

        prev = '0;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph == N_PHASES - 1) begin
                write_reg(bbwt_pkg::CFG_CENTER_X, 32'h0);
                write_reg(bbwt_pkg::CFG_CENTER_Y, 32'h0);
                write_reg(bbwt_pkg::CFG_CENTER_Z, 32'h0);
                write_reg(bbwt_pkg::CFG_HALF_X, 32'(bbwt_pkg::HALF_RESET));
                write_reg(bbwt_pkg::CFG_HALF_Y, 32'(bbwt_pkg::HALF_RESET));
                write_reg(bbwt_pkg::CFG_HALF_Z, 32'(bbwt_pkg::HALF_RESET));
            end else if (ph > 0) begin
                for (int r = 0; r < 6; r++) begin
                    if ($urandom_range(0, 3) != 0)
                        write_reg(bbwt_pkg::CFG_IDX_W'(r), pick_value());
                end
                if ($urandom_range(0, 2) == 0)
                    write_reg(bbwt_pkg::CFG_IDX_W'(6 + $urandom_range(0, 1)), $urandom());
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n > 0 && $urandom_range(0, 9) < 4) begin
                    mx = prev;
                    // near miss: one bit flipped in one element
                    if ($urandom_range(0, 7) == 0) mx[$urandom_range(0, 383)] ^= 1'b1;
                end else begin
                    mx = random_matrix();
                end
                pending_mx.push_back(mx);
                prev = mx;
            end
            wait_idle();
        end

        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
